// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("concurrent assertion failed");

// Concurrent check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("concurrent assertion failed");

`endif

// ----- src/lap3_pkg.sv -----
package lap3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int WCNT_W       = $clog2(MAX_WIDTH + 1);
   localparam int PIX_W        = 8;
   localparam int EDGE_W       = 11;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int ROW_W        = HEIGHT_REG_W + 1;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;

   localparam logic KIND_PIXEL = 1'b0;

   // Control and data of one item between the input register and the kernel
   typedef struct packed {
      logic             emit;
      logic             last;
      logic             col_zero;
      logic             clear;
      logic             above_en;
      logic             centre_en;
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
   } stage_type;

   // One line buffer entry: pixel of the row just above and of the row two above
   typedef struct packed {
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] above;
   } line_word_type;

endpackage

// ----- src/lap3_linebuf.sv -----
module lap3_linebuf (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [lap3_pkg::COL_W-1:0]    rd_addr,
   input  logic                          wr_en,
   input  logic [lap3_pkg::COL_W-1:0]    wr_addr,
   input  lap3_pkg::line_word_type       wr_data,
   output lap3_pkg::line_word_type       rd_data
);
   import lap3_pkg::*;

   line_word_type mem [MAX_WIDTH];
   line_word_type rd_data_ff;
   line_word_type byp_data_ff;
   logic          byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         // same-address write in this cycle: take the new word instead
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

// ----- src/lap3_kernel.sv -----
module lap3_kernel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               out_free,
   input  logic                               s1_valid,
   input  lap3_pkg::stage_type                stage,
   input  lap3_pkg::line_word_type            rd_word,
   output lap3_pkg::line_word_type            wr_word,
   output logic                               rsp_valid,
   output logic signed [lap3_pkg::EDGE_W-1:0] rsp_edge_value,
   output logic                               rsp_last
);
   import lap3_pkg::*;

   logic [PIX_W-1:0]  up2_ff, dn2_ff, mid1_ff, mid2_ff;
   logic [PIX_W-1:0]  above, centre, right;
   logic [EDGE_W-1:0] sum;
   logic              step;
   logic              rsp_valid_ff;
   logic [EDGE_W-1:0] rsp_edge_value_ff;
   logic              rsp_last_ff;

   assign step   = s1_valid && out_free;
   assign above  = stage.above_en  ? rd_word.above  : '0;
   assign centre = stage.centre_en ? rd_word.centre : '0;
   // right neighbour is padding when the centre is the last pixel of its row
   assign right  = stage.col_zero ? '0 : centre;

   assign wr_word.centre = stage.pix;
   assign wr_word.above  = centre;

   // wraps mod 2^EDGE_W, which is exact two's complement for the kernel range
   assign sum = EDGE_W'(up2_ff) + EDGE_W'(dn2_ff) + EDGE_W'(mid1_ff) + EDGE_W'(right)
              - (EDGE_W'(mid2_ff) << 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         up2_ff  <= '0;
         dn2_ff  <= '0;
         mid1_ff <= '0;
         mid2_ff <= '0;
      end else if (step) begin
         if (stage.clear) begin
            up2_ff  <= '0;
            dn2_ff  <= '0;
            mid1_ff <= '0;
            mid2_ff <= '0;
         end else begin
            up2_ff  <= above;
            dn2_ff  <= stage.pix;
            mid2_ff <= centre;
            mid1_ff <= stage.col_zero ? '0 : mid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && stage.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && stage.emit) begin
         rsp_edge_value_ff <= sum;
         rsp_last_ff       <= stage.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = $signed(rsp_edge_value_ff);
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- src/laplacian_3x3_edge_filter_core.sv -----
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | req_kind, req_pixel
// rsp      | out       | rsp_valid/rsp_stall | rsp_edge_value, rsp_last
// csr      | in        | csr_write           | csr_index, csr_wdata
//
// One item per cycle sustained unless a full result register is stalled; an item
// passes the input register (line buffer read), then kernel and result register.
// The line buffer is one read and one write port RAM, read on accept and
// written as the item leaves the input register, with a same-address bypass.
// Synchronous reset clears counters, window and valid flags; line buffers hold
// no reset. req_stall rises only while the result register is full and stalled.
module laplacian_3x3_edge_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic [lap3_pkg::PIX_W-1:0]         req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lap3_pkg::EDGE_W-1:0] rsp_edge_value,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [lap3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lap3_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lap3_pkg::*;

   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic                    s1_valid_ff;
   stage_type               s1_ff;
   stage_type               s1_in;

   logic [WCNT_W-1:0]       w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic [ROW_W-1:0]        h_p1, h_p2;
   logic                    col_zero, row_ge1, row_ge2, in_image, col_wrap;
   logic                    out_free, accept;
   line_word_type           rd_word, wr_word;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WCNT_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = WCNT_W'(image_width_ff);
      end
      h_eff = (image_height_ff == '0) ? HEIGHT_REG_W'(1) : image_height_ff;
   end

   assign h_p1     = ROW_W'(h_eff) + ROW_W'(1);
   assign h_p2     = ROW_W'(h_eff) + ROW_W'(2);
   assign col_zero = (col_ff == '0);
   assign row_ge1  = (row_ff != '0);
   assign row_ge2  = (row_ff >= ROW_W'(2));
   assign in_image = (row_ff < ROW_W'(h_eff));
   assign col_wrap = ((WCNT_W'(col_ff) + WCNT_W'(1)) >= w_eff);

   always_comb begin
      s1_in.emit      = (col_zero && row_ge2 && (row_ff < h_p2))
                     || (!col_zero && row_ge1 && (row_ff < h_p1));
      s1_in.last      = col_zero && (row_ff == h_p1);
      s1_in.col_zero  = col_zero;
      s1_in.clear     = col_zero && (row_ff >= h_p1);
      s1_in.above_en  = row_ge2;
      s1_in.centre_en = row_ge1;
      // pixels in the bottom padding count as zero
      s1_in.pix       = ((req_kind == KIND_PIXEL) && in_image) ? req_pixel : '0;
      s1_in.col       = col_ff;
   end

   assign out_free  = !rsp_valid || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[HEIGHT_REG_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (s1_in.clear) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || out_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   lap3_linebuf u_linebuf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_valid_ff && out_free),
      .wr_addr (s1_ff.col),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   lap3_kernel u_kernel (
      .clock          (clock),
      .reset          (reset),
      .out_free       (out_free),
      .s1_valid       (s1_valid_ff),
      .stage          (s1_ff),
      .rd_word        (rd_word),
      .wr_word        (wr_word),
      .rsp_valid      (rsp_valid),
      .rsp_edge_value (rsp_edge_value),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- src/lap3_checker.sv -----
`include "assert_macros.svh"

module lap3_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [lap3_pkg::EDGE_W-1:0] rsp_edge_value,
   input logic                               rsp_last
);
   import lap3_pkg::*;

   // a held result keeps its payload
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_edge_value) && $stable(rsp_last))

   // input side backs up only behind a full, stalled result register
   `ASSERT_RST(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // kernel response stays within its arithmetic range
   `ASSERT_RST(a_edge_range, clock, reset, rsp_valid |-> rsp_edge_value >= -11'sd1020 && rsp_edge_value <= 11'sd1020)

   // a new image needs at least three items, so two last results never abut
   `ASSERT_RST(a_last_gap, clock, reset, rsp_valid && rsp_last && !rsp_stall |=> !(rsp_valid && rsp_last))

   // reset empties both stages
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) && !reset |-> !rsp_valid && !req_stall)

endmodule

bind laplacian_3x3_edge_filter_core lap3_checker u_lap3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_edge_value (rsp_edge_value),
   .rsp_last       (rsp_last)
);
